### sv/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int KEY_W       = 8;
   localparam int CODE_W      = 64;
   localparam int LEN_W       = 4;
   localparam int ATT_W       = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [KEY_W-1:0] KEY_SUBMIT = 8'h41;
   localparam logic [KEY_W-1:0] KEY_ERASE  = 8'h44;

   localparam logic [LEN_W-1:0] RESET_PASSWORD_LENGTH = 4'd4;
   localparam logic [ATT_W-1:0] RESET_MAX_ATTEMPTS    = 4'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PASSWORD_CODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PASSWORD_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ATTEMPTS    = 2'd2;

   typedef enum logic [1:0] {
      PH_ENTER   = 2'd0,
      PH_CLOSED  = 2'd1,
      PH_LOCKOUT = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_STORED  = 3'd0,
      EV_ERASED  = 3'd1,
      EV_IGNORED = 3'd2,
      EV_GRANTED = 3'd3,
      EV_WRONG   = 3'd4,
      EV_LOCKOUT = 3'd5,
      EV_CLOSED  = 3'd6
   } event_type;

   typedef struct packed {
      logic [CODE_W-1:0] password_code;
      logic [LEN_W-1:0]  password_length;
      logic [ATT_W-1:0]  max_attempts;
   } cfg_type;

   typedef struct packed {
      event_type        event_code;
      logic [ATT_W-1:0] wrong_count;
      logic [LEN_W-1:0] entered_count;
      logic             gate_open;
   } result_type;

endpackage

### sv/keypad_code_lock_core.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_core
// Keypad code lock with entry buffer, submit/erase keys and attempt lockout.
//
//   channel  ports                                        direction
//   req      req_valid, req_stall, req_key_code           in (item = key)
//   rsp      rsp_valid, rsp_stall, rsp_event_code,        out (item = result)
//            rsp_wrong_count, rsp_entered_count, rsp_gate_open
//   csr      csr_we, csr_index, csr_wdata                 in (write only)
//
// One item per cycle sustained while the rsp channel does not stall.
// The key sits in the input register, is decided in one pass against the
// entry buffer and counters, and lands in the result register.
// A stalled result holds the input register, which then stalls req.
// Synchronous reset sets phase, counters, config and register valid flags to their defaults.
// ----------------------------------------------------------------------------
module keypad_code_lock_core #(
   parameter int MAX_PASSWORD_LEN = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kcl_pkg::KEY_W-1:0]         req_key_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_event_code,
   output logic [kcl_pkg::ATT_W-1:0]         rsp_wrong_count,
   output logic [kcl_pkg::LEN_W-1:0]         rsp_entered_count,
   output logic                              rsp_gate_open,
   input  logic                              csr_we,
   input  logic [kcl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kcl_pkg::CODE_W-1:0]        csr_wdata
);

   kcl_pkg::cfg_type          cfg_ff;
   logic                      s1_valid;
   logic [kcl_pkg::KEY_W-1:0] s1_key;
   logic                      out_free;
   logic                      advance;
   kcl_pkg::result_type       result;
   kcl_pkg::result_type       rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.password_code   <= '0;
         cfg_ff.password_length <= kcl_pkg::RESET_PASSWORD_LENGTH;
         cfg_ff.max_attempts    <= kcl_pkg::RESET_MAX_ATTEMPTS;
      end else if (csr_we) begin
         case (csr_index)
            kcl_pkg::CSR_PASSWORD_CODE: begin
               cfg_ff.password_code <= csr_wdata;
            end
            kcl_pkg::CSR_PASSWORD_LENGTH: begin
               cfg_ff.password_length <= csr_wdata[kcl_pkg::LEN_W-1:0];
            end
            kcl_pkg::CSR_MAX_ATTEMPTS: begin
               cfg_ff.max_attempts <= csr_wdata[kcl_pkg::ATT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign advance = s1_valid && out_free;

   kcl_in_reg u_in_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_key_code (req_key_code),
      .advance      (advance),
      .valid_ff     (s1_valid),
      .key_ff       (s1_key)
   );

   kcl_lock_fsm #(
      .MAX_PASSWORD_LEN (MAX_PASSWORD_LEN)
   ) u_lock_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .key    (s1_key),
      .cfg    (cfg_ff),
      .result (result)
   );

   kcl_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_event_code    = rsp_result.event_code;
   assign rsp_wrong_count   = rsp_result.wrong_count;
   assign rsp_entered_count = rsp_result.entered_count;
   assign rsp_gate_open     = rsp_result.gate_open;

endmodule

### sv/kcl_in_reg.sv
// ----------------------------------------------------------------------------
// kcl_in_reg
// Input register for key items, stalls while the held item cannot advance.
// ----------------------------------------------------------------------------
module kcl_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [kcl_pkg::KEY_W-1:0] req_key_code,
   input  logic                     advance,
   output logic                     valid_ff,
   output logic [kcl_pkg::KEY_W-1:0] key_ff
);

   logic load;
   logic valid_in;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= req_key_code;
      end
   end

endmodule

### sv/kcl_lock_fsm.sv
// ----------------------------------------------------------------------------
// kcl_lock_fsm
// Entry buffer, counters and lock phase; decides the result of one key.
// ----------------------------------------------------------------------------
module kcl_lock_fsm #(
   parameter int MAX_PASSWORD_LEN = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [kcl_pkg::KEY_W-1:0] key,
   input  kcl_pkg::cfg_type          cfg,
   output kcl_pkg::result_type       result
);

   localparam int CNT_W = $clog2(MAX_PASSWORD_LEN + 1);
   localparam int IDX_W = (MAX_PASSWORD_LEN > 1) ? $clog2(MAX_PASSWORD_LEN) : 1;
   localparam logic [kcl_pkg::LEN_W-1:0] MAX_LEN = kcl_pkg::LEN_W'(MAX_PASSWORD_LEN);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PASSWORD_LEN);

   kcl_pkg::phase_type                phase_ff, phase_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [kcl_pkg::ATT_W-1:0]         wrong_ff, wrong_in;
   logic [kcl_pkg::KEY_W-1:0]         buf_ff [MAX_PASSWORD_LEN];

   logic [kcl_pkg::LEN_W-1:0]         used_len;
   logic [kcl_pkg::ATT_W-1:0]         limit;
   logic [kcl_pkg::ATT_W:0]           wrong_inc;
   logic [kcl_pkg::ATT_W-1:0]         wrong_sat;
   logic [MAX_PASSWORD_LEN-1:0]       lane_ok;
   logic                              match;
   logic                              buf_we;
   kcl_pkg::event_type                event_code;
   logic                              gate;

   always_comb begin
      if (cfg.password_length == '0) begin
         used_len = kcl_pkg::LEN_W'(1);
      end else if (cfg.password_length > MAX_LEN) begin
         used_len = MAX_LEN;
      end else begin
         used_len = cfg.password_length;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PASSWORD_LEN; i++) begin
         lane_ok[i] = (kcl_pkg::LEN_W'(i) >= used_len) ||
                      (buf_ff[i] == cfg.password_code[8*i +: 8]);
      end
   end

   assign match = (kcl_pkg::LEN_W'(count_ff) == used_len) && (&lane_ok);

   assign limit     = (cfg.max_attempts == '0) ? kcl_pkg::ATT_W'(1) : cfg.max_attempts;
   assign wrong_inc = {1'b0, wrong_ff} + (kcl_pkg::ATT_W+1)'(1);
   assign wrong_sat = (wrong_inc > {1'b0, limit}) ? limit : wrong_inc[kcl_pkg::ATT_W-1:0];

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      wrong_in   = wrong_ff;
      buf_we     = 1'b0;
      gate       = 1'b0;
      event_code = kcl_pkg::EV_CLOSED;
      case (phase_ff)
         kcl_pkg::PH_LOCKOUT: begin
            event_code = kcl_pkg::EV_LOCKOUT;
         end
         kcl_pkg::PH_ENTER: begin
            if (key == kcl_pkg::KEY_ERASE) begin
               if (count_ff != '0) begin
                  count_in   = count_ff - CNT_W'(1);
                  event_code = kcl_pkg::EV_ERASED;
               end else begin
                  event_code = kcl_pkg::EV_IGNORED;
               end
            end else if (key == kcl_pkg::KEY_SUBMIT) begin
               count_in = '0;
               if (match) begin
                  wrong_in   = '0;
                  phase_in   = kcl_pkg::PH_CLOSED;
                  gate       = 1'b1;
                  event_code = kcl_pkg::EV_GRANTED;
               end else begin
                  wrong_in = wrong_sat;
                  if (wrong_sat >= limit) begin
                     phase_in   = kcl_pkg::PH_LOCKOUT;
                     event_code = kcl_pkg::EV_LOCKOUT;
                  end else begin
                     event_code = kcl_pkg::EV_WRONG;
                  end
               end
            end else if (count_ff < MAX_CNT) begin
               buf_we     = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               event_code = kcl_pkg::EV_STORED;
            end else begin
               event_code = kcl_pkg::EV_IGNORED;
            end
         end
         default: begin
            event_code = kcl_pkg::EV_CLOSED;
         end
      endcase
   end

   assign result.event_code    = event_code;
   assign result.wrong_count   = wrong_in;
   assign result.entered_count = kcl_pkg::LEN_W'(count_in);
   assign result.gate_open     = gate;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kcl_pkg::PH_ENTER;
         count_ff <= '0;
         wrong_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         wrong_ff <= wrong_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && buf_we) begin
         buf_ff[count_ff[IDX_W-1:0]] <= key;
      end
   end

endmodule

### sv/kcl_rsp_reg.sv
// ----------------------------------------------------------------------------
// kcl_rsp_reg
// Result register; holds an item until the receiver takes it.
// ----------------------------------------------------------------------------
module kcl_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  kcl_pkg::result_type result,
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output kcl_pkg::result_type rsp_result
);

   logic                valid_ff, valid_in;
   kcl_pkg::result_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

### sv/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level checks on the result channel of the keypad code lock.
// ----------------------------------------------------------------------------
module kcl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [2:0]                rsp_event_code,
   input logic [kcl_pkg::ATT_W-1:0] rsp_wrong_count,
   input logic [kcl_pkg::LEN_W-1:0] rsp_entered_count,
   input logic                      rsp_gate_open
);

   logic rsp_take;
   logic granted_ff;
   logic locked_ff;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         granted_ff <= 1'b0;
         locked_ff  <= 1'b0;
      end else if (rsp_take) begin
         if (rsp_event_code == kcl_pkg::EV_GRANTED) begin
            granted_ff <= 1'b1;
         end
         if (rsp_event_code == kcl_pkg::EV_LOCKOUT) begin
            locked_ff <= 1'b1;
         end
      end
   end

   a_gate_only_on_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gate_open |-> rsp_event_code == kcl_pkg::EV_GRANTED &&
                                     rsp_wrong_count == '0)
      else $error("gate open without grant");

   a_closed_after_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && granted_ff |-> rsp_event_code == kcl_pkg::EV_CLOSED)
      else $error("item after grant not closed");

   a_locked_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && locked_ff |-> rsp_event_code == kcl_pkg::EV_LOCKOUT)
      else $error("item after lockout not lockout");

   a_stored_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code == kcl_pkg::EV_STORED |-> rsp_entered_count != '0)
      else $error("stored key with empty entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code) &&
                                 $stable(rsp_entered_count))
      else $error("stalled result changed");

endmodule

bind keypad_code_lock_core kcl_checker u_kcl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_code    (rsp_event_code),
   .rsp_wrong_count   (rsp_wrong_count),
   .rsp_entered_count (rsp_entered_count),
   .rsp_gate_open     (rsp_gate_open)
);
